// ----- rtl/ksd_pkg.sv -----
// ----------------------------------------------------------------------------
// ksd_pkg
// Shared types and constants for the key scan, debounce and repeat block.
// ----------------------------------------------------------------------------
package ksd_pkg;

  localparam int NumKeys     = 11;
  localparam int CountW      = 8;
  localparam int RepeatW     = 16;
  localparam int CodeW       = 8;
  localparam int CheckShift  = 3;
  localparam int ApbAddrW    = 4;
  localparam int ApbDataW    = 32;

  localparam logic [CountW-1:0] LidLimitRst    = 8'd20;
  localparam logic [CountW-1:0] HoldLimitRst   = 8'd100;
  localparam logic [CountW-1:0] StartCountRst  = 8'd85;
  localparam logic [CountW-1:0] RepeatLoadRst  = 8'd85;

  typedef logic [NumKeys-1:0] key_map_t;

  typedef enum logic [1:0] {
    REG_LID_LIMIT   = 2'd0,
    REG_HOLD_LIMIT  = 2'd1,
    REG_START_COUNT = 2'd2,
    REG_REPEAT_LOAD = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CountW-1:0] lid_limit;
    logic [CountW-1:0] hold_limit;
    logic [CountW-1:0] start_count;
    logic [CountW-1:0] repeat_count_load;
  } cfg_t;

  typedef struct packed {
    logic             lid_pin;
    logic [CodeW-1:0] code_byte;
    logic [CodeW-1:0] check_byte;
    logic             ack_key;
    logic             ack_new;
  } scan_item_t;

  // key debounce view of one result
  typedef struct packed {
    key_map_t           key_action;
    logic               new_key;
    logic               key_down;
    logic [RepeatW-1:0] repeat_total;
    key_map_t           first_accepted;
  } key_out_t;

  typedef struct packed {
    key_out_t key;
    logic     lid_closed_out;
  } result_item_t;

endpackage

// ----- rtl/ksd_in_if.sv -----
// ----------------------------------------------------------------------------
// ksd_in_if
// Scan tick channel: valid/ready handshake with the tick fields.
// ----------------------------------------------------------------------------
interface ksd_in_if;
  logic                     valid;
  logic                     ready;
  logic                     lid_pin;
  logic [ksd_pkg::CodeW-1:0] code_byte;
  logic [ksd_pkg::CodeW-1:0] check_byte;
  logic                     ack_key;
  logic                     ack_new;

  modport source (
    output valid, lid_pin, code_byte, check_byte, ack_key, ack_new,
    input  ready
  );
  modport sink (
    input  valid, lid_pin, code_byte, check_byte, ack_key, ack_new,
    output ready
  );
endinterface

// ----- rtl/ksd_out_if.sv -----
// ----------------------------------------------------------------------------
// ksd_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface ksd_out_if;
  logic                        valid;
  logic                        ready;
  ksd_pkg::key_map_t           key_action;
  logic                        new_key;
  logic                        key_down;
  logic [ksd_pkg::RepeatW-1:0] repeat_total;
  ksd_pkg::key_map_t           first_accepted;
  logic                        lid_closed_out;

  modport source (
    output valid, key_action, new_key, key_down, repeat_total, first_accepted,
           lid_closed_out,
    input  ready
  );
  modport sink (
    input  valid, key_action, new_key, key_down, repeat_total, first_accepted,
           lid_closed_out,
    output ready
  );
endinterface

// ----- rtl/ksd_cfg.sv -----
// ----------------------------------------------------------------------------
// ksd_cfg
// APB register file holding the four 8-bit limit and load registers.
// ----------------------------------------------------------------------------
module ksd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ksd_pkg::ApbDataW-1:0]  pwdata,
  output logic [ksd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  output ksd_pkg::cfg_t                 cfg
);

  ksd_pkg::reg_idx_t idx;
  logic              wr_en;
  logic [ksd_pkg::CountW-1:0] rd_val;

  assign pready = 1'b1;
  assign idx    = ksd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lid_limit         <= ksd_pkg::LidLimitRst;
      cfg.hold_limit        <= ksd_pkg::HoldLimitRst;
      cfg.start_count       <= ksd_pkg::StartCountRst;
      cfg.repeat_count_load <= ksd_pkg::RepeatLoadRst;
    end else if (wr_en) begin
      unique case (idx)
        ksd_pkg::REG_LID_LIMIT:   cfg.lid_limit         <= pwdata[ksd_pkg::CountW-1:0];
        ksd_pkg::REG_HOLD_LIMIT:  cfg.hold_limit        <= pwdata[ksd_pkg::CountW-1:0];
        ksd_pkg::REG_START_COUNT: cfg.start_count       <= pwdata[ksd_pkg::CountW-1:0];
        ksd_pkg::REG_REPEAT_LOAD: cfg.repeat_count_load <= pwdata[ksd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ksd_pkg::REG_LID_LIMIT:   rd_val = cfg.lid_limit;
      ksd_pkg::REG_HOLD_LIMIT:  rd_val = cfg.hold_limit;
      ksd_pkg::REG_START_COUNT: rd_val = cfg.start_count;
      ksd_pkg::REG_REPEAT_LOAD: rd_val = cfg.repeat_count_load;
      default:                  rd_val = '0;
    endcase
  end

  assign prdata = ksd_pkg::ApbDataW'(rd_val);

endmodule

// ----- rtl/ksd_lid.sv -----
// ----------------------------------------------------------------------------
// ksd_lid
// Lid pin debounce: symmetric disagreement counter that flips the state.
// ----------------------------------------------------------------------------
module ksd_lid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        lid_pin,
  input  logic [ksd_pkg::CountW-1:0]  lid_limit,
  output logic                        lid_closed_next
);

  logic                       lid_closed;
  logic [ksd_pkg::CountW-1:0] lid_count;
  logic [ksd_pkg::CountW-1:0] lid_count_next;
  logic [ksd_pkg::CountW-1:0] count_inc;
  logic                       disagree;

  // pin high means open, so it disagrees with a closed state
  assign disagree  = lid_closed ? lid_pin : !lid_pin;
  assign count_inc = lid_count + 1'b1;

  always_comb begin
    lid_closed_next = lid_closed;
    lid_count_next  = '0;
    if (disagree) begin
      if (count_inc > lid_limit) begin
        lid_closed_next = !lid_closed;
      end else begin
        lid_count_next = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lid_closed <= 1'b0;
      lid_count  <= '0;
    end else if (adv) begin
      lid_closed <= lid_closed_next;
      lid_count  <= lid_count_next;
    end
  end

endmodule

// ----- rtl/ksd_key.sv -----
// ----------------------------------------------------------------------------
// ksd_key
// Key code check and decode, hold-count debounce with auto-repeat.
// ----------------------------------------------------------------------------
module ksd_key (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        lid_closed,
  input  ksd_pkg::scan_item_t         item,
  input  ksd_pkg::cfg_t               cfg,
  output ksd_pkg::key_out_t           res
);

  ksd_pkg::key_map_t           last_key, last_key_next;
  ksd_pkg::key_map_t           action_reg, action_next;
  ksd_pkg::key_map_t           first_key_reg, first_key_next;
  ksd_pkg::key_map_t           key;
  logic [ksd_pkg::CountW-1:0]  hold_count, hold_next, hold_inc;
  logic [ksd_pkg::RepeatW-1:0] repeat_reg, repeat_next;
  logic                        pressed_flag, pressed_next;
  logic                        first_flag, first_next;
  logic                        new_flag, new_next;
  logic                        check_ok;
  logic                        code_ok;

  assign check_ok = item.check_byte == (item.code_byte << ksd_pkg::CheckShift);
  assign code_ok  = (item.code_byte >= 8'd1) &&
                    (item.code_byte <= ksd_pkg::CodeW'(ksd_pkg::NumKeys));

  // code n sets bit n-1
  always_comb begin
    key = '0;
    if (lid_closed && check_ok && code_ok) begin
      key = ksd_pkg::key_map_t'(1) << (item.code_byte[3:0] - 4'd1);
    end
  end

  assign hold_inc = hold_count + 1'b1;

  always_comb begin
    last_key_next  = last_key;
    action_next    = action_reg;
    first_key_next = first_key_reg;
    hold_next      = hold_count;
    repeat_next    = repeat_reg;
    pressed_next   = pressed_flag;
    first_next     = first_flag;
    new_next       = new_flag;
    if (key == last_key) begin
      hold_next = hold_inc;
      if (hold_inc > cfg.hold_limit) begin
        action_next  = last_key;
        pressed_next = |last_key;
        repeat_next  = repeat_reg + 1'b1;
        if (first_flag) begin
          hold_next  = '0;
          first_next = 1'b0;
          if ((|key) && new_flag) begin
            first_key_next = last_key;
          end
        end else begin
          hold_next = cfg.repeat_count_load;
        end
      end
    end else begin
      // new_key only after a full release
      new_next      = !pressed_flag;
      action_next   = '0;
      repeat_next   = '0;
      first_next    = 1'b1;
      last_key_next = key;
      hold_next     = cfg.start_count;
    end
  end

  assign res.key_action     = action_next;
  assign res.new_key        = new_next;
  assign res.key_down       = pressed_next;
  assign res.repeat_total   = repeat_next;
  assign res.first_accepted = first_key_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_key      <= '0;
      action_reg    <= '0;
      first_key_reg <= '0;
      hold_count    <= '0;
      repeat_reg    <= '0;
      pressed_flag  <= 1'b0;
      first_flag    <= 1'b0;
      new_flag      <= 1'b0;
    end else if (adv) begin
      last_key      <= last_key_next;
      // clear-on-read takes effect after the value is reported
      action_reg    <= item.ack_key ? '0 : action_next;
      new_flag      <= item.ack_new ? 1'b0 : new_next;
      first_key_reg <= first_key_next;
      hold_count    <= hold_next;
      repeat_reg    <= repeat_next;
      pressed_flag  <= pressed_next;
      first_flag    <= first_next;
    end
  end

endmodule

// ----- rtl/key_scan_debounce_repeat.sv -----
// ----------------------------------------------------------------------------
// key_scan_debounce_repeat
// Lid debounce, key code check, key debounce with auto-repeat.
// ----------------------------------------------------------------------------
// Usage:
//   scan   - one transfer per scan tick: lid pin, code and check bytes, and
//            the clear-on-read acknowledges for key action and new-key flag.
//   result - exactly one transfer per scan tick, in order, with the key
//            action, flags, repeat count, first key and debounced lid state.
//   APB    - four 8-bit registers at byte addresses 0, 4, 8, 12: lid limit,
//            hold limit, start count, repeat reload. Write only while idle.
// A scan tick is first captured in the input register, where it waits until
// the result slot frees; it is evaluated, with the state updated, as it moves
// into the result register, from which the result is offered.
// Throughput is one tick per cycle while results are taken; the input register
// and the result register each hold one tick, so a new tick is taken while a
// result waits. When the receiver stalls, the result holds and the input
// register fills; scan ready then drops until the result is taken.
// Reset (synchronous, active high) clears all debounce state, empties both
// registers and loads the register defaults 20, 100, 85, 85.
// ----------------------------------------------------------------------------
module key_scan_debounce_repeat (
  input  logic                          clk,
  input  logic                          rst,
  ksd_in_if.sink                        scan,
  ksd_out_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ksd_pkg::ApbAddrW-1:0]  paddr,
  input  logic [ksd_pkg::ApbDataW-1:0]  pwdata,
  output logic [ksd_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  ksd_pkg::cfg_t          cfg;
  ksd_pkg::scan_item_t    s1_item;
  ksd_pkg::result_item_t  r_item;
  ksd_pkg::key_out_t      key_res;
  logic                   s1_valid;
  logic                   r_valid;
  logic                   adv;
  logic                   lid_closed_next;

  ksd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the tick in the input register is evaluated when the result slot frees
  assign adv        = s1_valid && (!r_valid || result.ready);
  assign scan.ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan.ready) begin
      s1_valid <= scan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      s1_item.lid_pin    <= scan.lid_pin;
      s1_item.code_byte  <= scan.code_byte;
      s1_item.check_byte <= scan.check_byte;
      s1_item.ack_key    <= scan.ack_key;
      s1_item.ack_new    <= scan.ack_new;
    end
  end

  ksd_lid u_lid (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .lid_pin         (s1_item.lid_pin),
    .lid_limit       (cfg.lid_limit),
    .lid_closed_next (lid_closed_next)
  );

  ksd_key u_key (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .lid_closed (lid_closed_next),
    .item       (s1_item),
    .cfg        (cfg),
    .res        (key_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (adv) begin
      r_valid <= 1'b1;
    end else if (result.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_item.key            <= key_res;
      r_item.lid_closed_out <= lid_closed_next;
    end
  end

  assign result.valid          = r_valid;
  assign result.key_action     = r_item.key.key_action;
  assign result.new_key        = r_item.key.new_key;
  assign result.key_down       = r_item.key.key_down;
  assign result.repeat_total   = r_item.key.repeat_total;
  assign result.first_accepted = r_item.key.first_accepted;
  assign result.lid_closed_out = r_item.lid_closed_out;

  // an empty result slot never blocks the scan side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !r_valid |-> scan.ready)
    else $error("scan stalled with empty result register");

  // every evaluated tick shows up as a result
  a_adv_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> r_valid)
    else $error("evaluated tick did not reach the result register");

  // a single key at most in the reported maps
  a_onehot_maps: assert property (@(posedge clk) disable iff (rst)
    r_valid |-> ($onehot0(result.key_action) && $onehot0(result.first_accepted)))
    else $error("key map holds more than one key");

  // a reported key action implies the key is down
  a_action_down: assert property (@(posedge clk) disable iff (rst)
    (r_valid && (result.key_action != '0)) |-> result.key_down)
    else $error("key action reported without key down");

endmodule
